### rtl/core/bsa_pkg.sv
`default_nettype none

package bsa_pkg;

    // default sizing
    localparam int PROCESSES_DEF      = 8;
    localparam int RESOURCE_TYPES_DEF = 3;
    localparam int COUNT_WIDTH_DEF    = 8;
    // amount fields carried by a request
    localparam int AMOUNT_FIELDS      = 3;

    // request modes
    localparam logic [2:0] MODE_LOAD_MAX  = 3'd0;
    localparam logic [2:0] MODE_LOAD_ALC  = 3'd1;
    localparam logic [2:0] MODE_SET_POOL  = 3'd2;
    localparam logic [2:0] MODE_REQUEST   = 3'd3;
    localparam logic [2:0] MODE_TRIAL     = 3'd4;
    localparam logic [2:0] MODE_CHECK     = 3'd5;

    // result status codes
    localparam logic [3:0] ST_LOADED       = 4'd0;
    localparam logic [3:0] ST_GRANTED      = 4'd1;
    localparam logic [3:0] ST_OVER_NEED    = 4'd2;
    localparam logic [3:0] ST_OVER_AVAIL   = 4'd3;
    localparam logic [3:0] ST_ROLLED_BACK  = 4'd4;
    localparam logic [3:0] ST_TRIAL_SAFE   = 4'd5;
    localparam logic [3:0] ST_TRIAL_UNSAFE = 4'd6;
    localparam logic [3:0] ST_CUR_SAFE     = 4'd7;
    localparam logic [3:0] ST_CUR_UNSAFE   = 4'd8;
    localparam logic [3:0] ST_BAD_SLOT     = 4'd9;

    typedef struct packed {
        logic [2:0] mode;
        logic [2:0] pid;
        logic [7:0] amount_0;
        logic [7:0] amount_1;
        logic [7:0] amount_2;
    } t_req;

    typedef struct packed {
        logic [3:0] status;
        logic [2:0] seq_pid;
        logic       seq_valid;
        logic       last;
    } t_res;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROW_CHK,
        S_SCAN,
        S_COMMIT,
        S_RELEASE,
        S_EMIT
    } t_state;

endpackage

`default_nettype wire

### rtl/core/bankers_safety_allocator.sv
// channel   | direction | handshake               | payload
// ----------+-----------+-------------------------+---------------------------
// request   | in        | start high, busy low    | i_req  (t_req)
// result    | out       | o_res_vld, one cycle    | o_res  (t_res)
//
// loads, pool writes, bad slots: result on the cycle after the request, busy stays low
// check: scan passes over the slots (at most PROCESSES + 1 passes, the last one finds
//   nothing), then the results, one per cycle
// request/trial: a row read, then the scan; a grant adds a commit step and a release
//   sweep over all slots; the pipelined row read of the safety scan takes one slot a cycle
// reset is synchronous, active low: all slots inactive, rows and pool read as zero
// results cannot be stalled; busy stays high until the last result is driven
`default_nettype none

module bankers_safety_allocator import bsa_pkg::*; #(
    parameter int PROCESSES      = PROCESSES_DEF,
    parameter int RESOURCE_TYPES = RESOURCE_TYPES_DEF,
    parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_res_vld,
    output t_res o_res
);

    localparam int IDX_W  = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int CNT_W  = $clog2(PROCESSES + 1);
    localparam int WORK_W = COUNT_WIDTH + CNT_W;
    localparam int ROW_W  = RESOURCE_TYPES * COUNT_WIDTH;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PROCESSES - 1);

    // control state
    t_state                r_state, n_state;
    logic [PROCESSES-1:0]  r_active, n_active;
    logic [PROCESSES-1:0]  r_dvld, n_dvld;     // demand row written since reset/release
    logic [PROCESSES-1:0]  r_avld, n_avld;     // allocation row written since reset/release
    logic                  r_out_vld, n_out_vld;
    logic [COUNT_WIDTH-1:0] r_pool [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] n_pool [RESOURCE_TYPES];

    // working registers of the current request
    logic [2:0]             r_mode, n_mode;
    logic [IDX_W-1:0]       r_pid, n_pid;
    logic [COUNT_WIDTH-1:0] r_amt [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] n_amt [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] r_prow_a [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] n_prow_a [RESOURCE_TYPES];
    logic [WORK_W-1:0]      r_work [RESOURCE_TYPES];
    logic [WORK_W-1:0]      n_work [RESOURCE_TYPES];
    logic [PROCESSES-1:0]   r_done, n_done;
    logic                   r_prog, n_prog;
    logic [IDX_W-1:0]       r_rd, n_rd;
    logic [IDX_W-1:0]       r_ev;
    logic                   r_ev_vld, n_ev_vld;
    logic [CNT_W-1:0]       r_cnt, n_cnt;
    logic [CNT_W-1:0]       r_k, n_k;
    logic [3:0]             r_stat, n_stat;
    t_res                   r_out, n_out;
    logic [IDX_W-1:0]       r_order [PROCESSES];

    // row memories
    logic [ROW_W-1:0] m_dem [PROCESSES];
    logic [ROW_W-1:0] m_alc [PROCESSES];
    logic [ROW_W-1:0] r_dem_q, r_alc_q;
    logic [IDX_W-1:0] rd_addr, wr_addr;
    logic             dem_we, alc_we, ord_we;
    logic [ROW_W-1:0] dem_wd, alc_wd;

    // request decode
    logic                   accept;
    logic [31:0]            pid_ext;
    logic                   pid_ok;
    logic [IDX_W-1:0]       in_idx;
    logic [COUNT_WIDTH-1:0] in_amt [RESOURCE_TYPES];
    logic [ROW_W-1:0]       in_row;

    // row evaluation
    logic [COUNT_WIDTH-1:0] ev_d [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] ev_a [RESOURCE_TYPES];
    logic [COUNT_WIDTH-1:0] ev_need [RESOURCE_TYPES];
    logic                   add_en, fits, nz_need, over_need, over_pool;
    logic                   take, prog_now, at_end, scan_fin, safe, rel, emit_last;
    logic [PROCESSES-1:0]   ev_bit, done_nx;
    logic [31:0]            ord_ext;

    function automatic t_res single_res(input logic [3:0] st);
        t_res res;
        res.status    = st;
        res.seq_pid   = '0;
        res.seq_valid = 1'b0;
        res.last      = 1'b1;
        return res;
    endfunction

    assign busy      = (r_state != S_IDLE);
    assign accept    = start & ~busy;
    assign o_res_vld = r_out_vld;
    assign o_res     = r_out;

    // slot index and amounts of the incoming request
    always_comb begin
        pid_ext = 32'(i_req.pid);
        pid_ok  = pid_ext < 32'(PROCESSES);
        in_idx  = pid_ok ? pid_ext[IDX_W-1:0] : '0;
    end

    always_comb begin
        logic [15:0] a16;
        in_row = '0;
        for (int t = 0; t < RESOURCE_TYPES; t++) begin
            case (t)
                0:       a16 = {8'b0, i_req.amount_0};
                1:       a16 = {8'b0, i_req.amount_1};
                2:       a16 = {8'b0, i_req.amount_2};
                default: a16 = '0;
            endcase
            in_amt[t] = (t < AMOUNT_FIELDS) ? a16[COUNT_WIDTH-1:0] : '0;
            in_row[t*COUNT_WIDTH +: COUNT_WIDTH] = in_amt[t];
        end
    end

    // in idle the memories look at the requested slot, otherwise at the sweep pointer
    assign rd_addr = (r_state == S_IDLE) ? in_idx : r_rd;

    // row under evaluation, unwritten rows read as zero, trial amount forwarded into pid's row
    always_comb begin
        logic [COUNT_WIDTH-1:0] a_raw;
        add_en    = (r_state == S_SCAN) && (r_ev == r_pid);
        fits      = 1'b1;
        nz_need   = 1'b0;
        over_need = 1'b0;
        over_pool = 1'b0;
        for (int t = 0; t < RESOURCE_TYPES; t++) begin
            ev_d[t] = r_dvld[r_ev] ? r_dem_q[t*COUNT_WIDTH +: COUNT_WIDTH] : '0;
            a_raw   = r_avld[r_ev] ? r_alc_q[t*COUNT_WIDTH +: COUNT_WIDTH] : '0;
            ev_a[t] = add_en ? a_raw + r_amt[t] : a_raw;
            ev_need[t] = (ev_d[t] > ev_a[t]) ? ev_d[t] - ev_a[t] : '0;
            if (WORK_W'(ev_need[t]) > r_work[t]) begin
                fits = 1'b0;
            end
            if (ev_need[t] != '0) begin
                nz_need = 1'b1;
            end
            if (r_amt[t] > ev_need[t]) begin
                over_need = 1'b1;
            end
            if (r_amt[t] > r_pool[t]) begin
                over_pool = 1'b1;
            end
        end
    end

    // scan and release decisions
    always_comb begin
        ev_bit    = PROCESSES'(1) << r_ev;
        take      = r_ev_vld & r_active[r_ev] & ~r_done[r_ev] & fits;
        done_nx   = take ? (r_done | ev_bit) : r_done;
        prog_now  = r_prog | take;
        at_end    = r_ev_vld & (r_ev == LAST_IDX);
        scan_fin  = (r_state == S_SCAN) & at_end & ~prog_now;
        safe      = (done_nx == r_active);
        rel       = (r_state == S_RELEASE) & r_ev_vld & r_active[r_ev] & ~nz_need;
        emit_last = (r_cnt == '0) || (CNT_W'(r_k + 1'b1) == r_cnt);
        ord_ext   = 32'(r_order[r_k[IDX_W-1:0]]);
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.mode) inside
                        MODE_REQUEST, MODE_TRIAL: begin
                            if (pid_ok && r_active[in_idx]) begin
                                n_state = S_ROW_CHK;
                            end
                        end
                        MODE_CHECK: n_state = S_SCAN;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_ROW_CHK: begin
                n_state = (over_need || over_pool) ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (scan_fin) begin
                    if (!safe) begin
                        n_state = S_IDLE;
                    end else if (r_mode == MODE_REQUEST) begin
                        n_state = S_COMMIT;
                    end else begin
                        n_state = S_EMIT;
                    end
                end
            end
            S_COMMIT:  n_state = S_RELEASE;
            S_RELEASE: begin
                if (at_end) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (emit_last) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic [COUNT_WIDTH:0] sum;
        sum       = '0;
        n_active  = r_active;
        n_dvld    = r_dvld;
        n_avld    = r_avld;
        n_pool    = r_pool;
        n_mode    = r_mode;
        n_pid     = r_pid;
        n_amt     = r_amt;
        n_prow_a  = r_prow_a;
        n_work    = r_work;
        n_done    = r_done;
        n_prog    = r_prog;
        n_rd      = r_rd;
        n_ev_vld  = 1'b0;
        n_cnt     = r_cnt;
        n_k       = r_k;
        n_stat    = r_stat;
        n_out_vld = 1'b0;
        n_out     = r_out;
        dem_we    = 1'b0;
        alc_we    = 1'b0;
        ord_we    = 1'b0;
        wr_addr   = in_idx;
        dem_wd    = in_row;
        alc_wd    = in_row;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_req.mode) inside
                        MODE_LOAD_MAX, MODE_LOAD_ALC: begin
                            n_out_vld = 1'b1;
                            n_out     = single_res(pid_ok ? ST_LOADED : ST_BAD_SLOT);
                            if (pid_ok) begin
                                if (i_req.mode == MODE_LOAD_MAX) begin
                                    dem_we           = 1'b1;
                                    n_dvld[in_idx]   = 1'b1;
                                    n_active[in_idx] = 1'b1;
                                end else begin
                                    alc_we         = 1'b1;
                                    n_avld[in_idx] = 1'b1;
                                end
                            end
                        end
                        MODE_SET_POOL: begin
                            n_pool    = in_amt;
                            n_out_vld = 1'b1;
                            n_out     = single_res(ST_LOADED);
                        end
                        MODE_REQUEST, MODE_TRIAL: begin
                            if (pid_ok && r_active[in_idx]) begin
                                n_mode = i_req.mode;
                                n_pid  = in_idx;
                                n_amt  = in_amt;
                            end else begin
                                n_out_vld = 1'b1;
                                n_out     = single_res(ST_BAD_SLOT);
                            end
                        end
                        MODE_CHECK: begin
                            // zero amount keeps the shared scan path untouched
                            n_mode = i_req.mode;
                            n_pid  = '0;
                            for (int t = 0; t < RESOURCE_TYPES; t++) begin
                                n_amt[t]  = '0;
                                n_work[t] = WORK_W'(r_pool[t]);
                            end
                            n_done = '0;
                            n_cnt  = '0;
                            n_prog = 1'b0;
                            n_rd   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            S_ROW_CHK: begin
                n_prow_a = ev_a;
                if (over_need) begin
                    n_out_vld = 1'b1;
                    n_out     = single_res(ST_OVER_NEED);
                end else if (over_pool) begin
                    n_out_vld = 1'b1;
                    n_out     = single_res(ST_OVER_AVAIL);
                end else begin
                    for (int t = 0; t < RESOURCE_TYPES; t++) begin
                        n_work[t] = WORK_W'(r_pool[t] - r_amt[t]);
                    end
                    n_done = '0;
                    n_cnt  = '0;
                    n_prog = 1'b0;
                    n_rd   = '0;
                end
            end
            S_SCAN: begin
                n_rd     = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
                n_ev_vld = 1'b1;
                if (take) begin
                    for (int t = 0; t < RESOURCE_TYPES; t++) begin
                        n_work[t] = r_work[t] + WORK_W'(ev_a[t]);
                    end
                    n_done = done_nx;
                    ord_we = 1'b1;
                    n_cnt  = r_cnt + 1'b1;
                end
                n_prog = at_end ? 1'b0 : prog_now;
                if (scan_fin) begin
                    n_k = '0;
                    if (!safe) begin
                        n_out_vld = 1'b1;
                        case (r_mode)
                            MODE_REQUEST: n_out = single_res(ST_ROLLED_BACK);
                            MODE_TRIAL:   n_out = single_res(ST_TRIAL_UNSAFE);
                            default:      n_out = single_res(ST_CUR_UNSAFE);
                        endcase
                    end else begin
                        case (r_mode)
                            MODE_REQUEST: n_stat = ST_GRANTED;
                            MODE_TRIAL:   n_stat = ST_TRIAL_SAFE;
                            default:      n_stat = ST_CUR_SAFE;
                        endcase
                    end
                end
            end
            S_COMMIT: begin
                alc_we  = 1'b1;
                wr_addr = r_pid;
                for (int t = 0; t < RESOURCE_TYPES; t++) begin
                    n_pool[t] = r_pool[t] - r_amt[t];
                    alc_wd[t*COUNT_WIDTH +: COUNT_WIDTH] = r_prow_a[t] + r_amt[t];
                end
                n_avld[r_pid] = 1'b1;
                n_rd          = '0;
            end
            S_RELEASE: begin
                n_rd     = (r_rd == LAST_IDX) ? '0 : r_rd + 1'b1;
                n_ev_vld = ~at_end;
                if (rel) begin
                    // freed slot returns its allocation, pool saturates
                    for (int t = 0; t < RESOURCE_TYPES; t++) begin
                        sum = {1'b0, r_pool[t]} + {1'b0, ev_a[t]};
                        n_pool[t] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
                    end
                    n_active = r_active & ~ev_bit;
                    n_dvld   = r_dvld & ~ev_bit;
                    n_avld   = r_avld & ~ev_bit;
                end
            end
            S_EMIT: begin
                n_out_vld    = 1'b1;
                n_out.status = r_stat;
                if (r_cnt == '0) begin
                    n_out.seq_pid   = '0;
                    n_out.seq_valid = 1'b0;
                    n_out.last      = 1'b1;
                end else begin
                    n_out.seq_pid   = ord_ext[2:0];
                    n_out.seq_valid = 1'b1;
                    n_out.last      = emit_last;
                end
                n_k = r_k + 1'b1;
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_active  <= '0;
            r_dvld    <= '0;
            r_avld    <= '0;
            r_out_vld <= 1'b0;
            r_ev_vld  <= 1'b0;
            for (int t = 0; t < RESOURCE_TYPES; t++) begin
                r_pool[t] <= '0;
            end
        end else begin
            r_state   <= n_state;
            r_active  <= n_active;
            r_dvld    <= n_dvld;
            r_avld    <= n_avld;
            r_out_vld <= n_out_vld;
            r_ev_vld  <= n_ev_vld;
            r_pool    <= n_pool;
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_mode   <= n_mode;
        r_pid    <= n_pid;
        r_amt    <= n_amt;
        r_prow_a <= n_prow_a;
        r_work   <= n_work;
        r_done   <= n_done;
        r_prog   <= n_prog;
        r_rd     <= n_rd;
        r_ev     <= rd_addr;
        r_cnt    <= n_cnt;
        r_k      <= n_k;
        r_stat   <= n_stat;
        r_out    <= n_out;
        if (ord_we) begin
            r_order[r_cnt[IDX_W-1:0]] <= r_ev;
        end
    end

    // row memories, one write and one registered read each
    always_ff @(posedge i_clk) begin
        if (dem_we) begin
            m_dem[wr_addr] <= dem_wd;
        end
        if (alc_we) begin
            m_alc[wr_addr] <= alc_wd;
        end
        r_dem_q <= m_dem[rd_addr];
        r_alc_q <= m_alc[rd_addr];
    end

endmodule

`default_nettype wire

### rtl/core/bsa_checker.sv
`default_nettype none

module bsa_checker import bsa_pkg::*; (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire t_req i_req,
    input wire logic o_res_vld,
    input wire t_res o_res
);

    // a sequence burst has no gaps
    a_burst_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && !o_res.last |=> o_res_vld)
        else $error("result burst broken");

    // all results of one request carry one status
    a_burst_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && !o_res.last |=> o_res.status == $past(o_res.status))
        else $error("status changed within a burst");

    // a result without a sequence entry ends its request
    a_plain_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld && !o_res.seq_valid |-> o_res.last)
        else $error("plain result not last");

    // setting the pool answers on the next cycle
    a_pool_answer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_req.mode == MODE_SET_POOL |=>
            o_res_vld && o_res.status == ST_LOADED && !busy)
        else $error("pool write not answered");

    a_status_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_vld |-> o_res.status <= ST_BAD_SLOT)
        else $error("status out of range");

endmodule

bind bankers_safety_allocator bsa_checker u_bsa_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_req     (i_req),
    .o_res_vld (o_res_vld),
    .o_res     (o_res)
);

`default_nettype wire

### tb/sv/tb_bankers_safety_allocator.sv
`timescale 1ns / 100ps

module tb_bankers_safety_allocator;
    import bsa_pkg::*;

    localparam int NSLOT = PROCESSES_DEF;
    localparam int NTYPE = RESOURCE_TYPES_DEF;
    localparam int CMAXV = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_ITEMS = 330;
    localparam logic [2:0] MODE_UNUSED_6 = 3'd6;
    localparam logic [2:0] MODE_UNUSED_7 = 3'd7;

    logic i_clk;
    logic i_rst_n;
    logic start;
    logic busy;
    t_req i_req;
    logic o_res_vld;
    t_res o_res;

    bankers_safety_allocator uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_req(i_req),
        .o_res_vld(o_res_vld),
        .o_res(o_res)
    );

    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // shadow copy of the allocation tables
    int demand_tbl[NSLOT][NTYPE];
    int alloc_tbl[NSLOT][NTYPE];
    int pool_now[NTYPE];
    logic [NSLOT-1:0] live_slots;

    // scratch for the safety scan
    int scan_alloc[NSLOT][NTYPE];
    int scan_pool[NTYPE];
    int safe_order[NSLOT];
    int safe_count;

    t_res expected_results[$];
    int errors;
    int idle_pct;
    int stall_cycles;

    function automatic int slot_need(int p, int t);
        return demand_tbl[p][t] > scan_alloc[p][t] ? demand_tbl[p][t] - scan_alloc[p][t] : 0;
    endfunction

    // repeated in-order passes over unfinished live slots
    function automatic bit run_safety_scan();
        int work[NTYPE];
        logic [NSLOT-1:0] done;
        bit progress;
        bit fits;
        done = '0;
        progress = 1'b1;
        safe_count = 0;
        for (int t = 0; t < NTYPE; t++) work[t] = scan_pool[t];
        while (progress) begin
            progress = 1'b0;
            for (int p = 0; p < NSLOT; p++) begin
                if (!live_slots[p] || done[p]) continue;
                fits = 1'b1;
                for (int t = 0; t < NTYPE; t++)
                    if (slot_need(p, t) > work[t]) fits = 1'b0;
                if (fits) begin
                    for (int t = 0; t < NTYPE; t++) work[t] += scan_alloc[p][t];
                    done[p] = 1'b1;
                    safe_order[safe_count] = p;
                    safe_count++;
                    progress = 1'b1;
                end
            end
        end
        return done == live_slots;
    endfunction

    // append one expected result at the tail
    task automatic queue_result(t_res r);
        expected_results = {expected_results, r};
    endtask

    task automatic push_single(logic [3:0] st);
        t_res r;
        r.status = st;
        r.seq_pid = '0;
        r.seq_valid = 1'b0;
        r.last = 1'b1;
        queue_result(r);
    endtask

    task automatic push_sequence(logic [3:0] st);
        t_res r;
        if (safe_count == 0) begin
            push_single(st);
        end else begin
            for (int k = 0; k < safe_count; k++) begin
                r.status = st;
                r.seq_pid = safe_order[k][2:0];
                r.seq_valid = 1'b1;
                r.last = (k == safe_count - 1);
                queue_result(r);
            end
        end
    endtask

    // expected results of one accepted request, and the state update
    task automatic predict_allocation(t_req rq);
        int amt[NTYPE];
        int p;
        int s;
        bit zero;
        bit refused;
        p = int'(rq.pid);
        amt[0] = int'(rq.amount_0);
        amt[1] = int'(rq.amount_1);
        amt[2] = int'(rq.amount_2);
        for (int q = 0; q < NSLOT; q++)
            for (int t = 0; t < NTYPE; t++) scan_alloc[q][t] = alloc_tbl[q][t];
        case (rq.mode)
            MODE_CHECK: begin
                for (int t = 0; t < NTYPE; t++) scan_pool[t] = pool_now[t];
                if (run_safety_scan()) push_sequence(ST_CUR_SAFE);
                else push_single(ST_CUR_UNSAFE);
            end
            MODE_SET_POOL: begin
                for (int t = 0; t < NTYPE; t++) pool_now[t] = amt[t];
                push_single(ST_LOADED);
            end
            MODE_LOAD_MAX, MODE_LOAD_ALC: begin
                for (int t = 0; t < NTYPE; t++)
                    if (rq.mode == MODE_LOAD_MAX) demand_tbl[p][t] = amt[t];
                    else alloc_tbl[p][t] = amt[t];
                if (rq.mode == MODE_LOAD_MAX) live_slots[p] = 1'b1;
                push_single(ST_LOADED);
            end
            MODE_REQUEST, MODE_TRIAL: begin
                refused = 1'b0;
                if (!live_slots[p]) begin
                    push_single(ST_BAD_SLOT);
                    refused = 1'b1;
                end
                for (int t = 0; t < NTYPE; t++)
                    if (!refused && amt[t] > slot_need(p, t)) begin
                        push_single(ST_OVER_NEED);
                        refused = 1'b1;
                    end
                for (int t = 0; t < NTYPE; t++)
                    if (!refused && amt[t] > pool_now[t]) begin
                        push_single(ST_OVER_AVAIL);
                        refused = 1'b1;
                    end
                if (!refused) begin
                    for (int t = 0; t < NTYPE; t++) begin
                        scan_pool[t] = pool_now[t] - amt[t];
                        scan_alloc[p][t] += amt[t];
                    end
                    if (!run_safety_scan()) begin
                        push_single(rq.mode == MODE_REQUEST ? ST_ROLLED_BACK : ST_TRIAL_UNSAFE);
                    end else if (rq.mode == MODE_TRIAL) begin
                        push_sequence(ST_TRIAL_SAFE);
                    end else begin
                        // commit, then release every live slot with nothing left to need
                        for (int q = 0; q < NSLOT; q++)
                            for (int t = 0; t < NTYPE; t++) alloc_tbl[q][t] = scan_alloc[q][t];
                        for (int t = 0; t < NTYPE; t++) pool_now[t] = scan_pool[t];
                        for (int q = 0; q < NSLOT; q++) begin
                            if (!live_slots[q]) continue;
                            zero = 1'b1;
                            for (int t = 0; t < NTYPE; t++)
                                if (demand_tbl[q][t] > alloc_tbl[q][t]) zero = 1'b0;
                            if (!zero) continue;
                            for (int t = 0; t < NTYPE; t++) begin
                                s = pool_now[t] + alloc_tbl[q][t];
                                pool_now[t] = s > CMAXV ? CMAXV : s;
                                alloc_tbl[q][t] = 0;
                                demand_tbl[q][t] = 0;
                            end
                            live_slots[q] = 1'b0;
                        end
                        push_sequence(ST_GRANTED);
                    end
                end
            end
            default: ; // unused modes give no result
        endcase
    endtask

    task automatic report_mismatch(string what, int got, int want);
        errors++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // result checker: strobe cannot be held off, compare with oldest expectation
    always @(posedge i_clk) begin
        t_res want;
        if (i_rst_n && o_res_vld) begin
            if (expected_results.size() == 0) begin
                report_mismatch("unexpected result status", o_res.status, -1);
            end else begin
                want = expected_results.pop_front();
                if (o_res.status !== want.status)
                    report_mismatch("status", o_res.status, want.status);
                if (o_res.seq_pid !== want.seq_pid)
                    report_mismatch("seq_pid", o_res.seq_pid, want.seq_pid);
                if (o_res.seq_valid !== want.seq_valid)
                    report_mismatch("seq_valid", o_res.seq_valid, want.seq_valid);
                if (o_res.last !== want.last)
                    report_mismatch("last", o_res.last, want.last);
            end
        end
    end

    // watchdog on cycles with no request accepted and no result
    always @(posedge i_clk) begin
        if (!i_rst_n || o_res_vld || (start && !busy)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // drive one request from a falling edge and hold it until accepted
    task automatic send_request(t_req rq);
        bit taken;
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            start <= 1'b0;
            @(negedge i_clk);
        end
        start <= 1'b1;
        i_req <= rq;
        taken = 1'b0;
        while (!taken) begin
            #1;
            taken = !busy;
            @(posedge i_clk);
        end
        predict_allocation(rq);
    endtask

    task automatic send_fields(logic [2:0] m, logic [2:0] p, int a0, int a1, int a2);
        t_req rq;
        rq.mode = m;
        rq.pid = p;
        rq.amount_0 = a0[7:0];
        rq.amount_1 = a1[7:0];
        rq.amount_2 = a2[7:0];
        send_request(rq);
    endtask

    task automatic test_loads_and_empty_state();
        send_fields(MODE_CHECK, 3'd0, 0, 0, 0);              // empty sequence
        send_fields(MODE_REQUEST, 3'd2, 1, 0, 0);            // bad slot, inactive
        send_fields(MODE_TRIAL, 3'd7, 0, 0, 0);              // bad slot, trial
        send_fields(MODE_LOAD_ALC, 3'd5, 4, 4, 4);           // alloc on inactive slot
        send_fields(MODE_UNUSED_6, 3'd1, 255, 255, 255);     // ignored
        send_fields(MODE_UNUSED_7, 3'd6, 0, 0, 0);
        send_fields(MODE_SET_POOL, 3'd0, 255, 255, 255);
        send_fields(MODE_SET_POOL, 3'd3, 3, 3, 2);
    endtask

    task automatic test_bound_checks_and_scan();
        send_fields(MODE_LOAD_MAX, 3'd0, 7, 5, 3);
        send_fields(MODE_LOAD_ALC, 3'd0, 0, 1, 0);
        send_fields(MODE_LOAD_MAX, 3'd1, 3, 2, 2);
        send_fields(MODE_LOAD_ALC, 3'd1, 2, 0, 0);
        send_fields(MODE_LOAD_MAX, 3'd7, 9, 0, 2);
        send_fields(MODE_LOAD_ALC, 3'd7, 3, 0, 2);
        send_fields(MODE_LOAD_MAX, 3'd5, 2, 2, 2);           // alloc above demand, zero need
        send_fields(MODE_CHECK, 3'd0, 0, 0, 0);
        send_fields(MODE_REQUEST, 3'd0, 8, 0, 0);            // over need
        send_fields(MODE_REQUEST, 3'd7, 4, 0, 0);            // over available
        send_fields(MODE_TRIAL, 3'd1, 1, 2, 2);
        send_fields(MODE_REQUEST, 3'd0, 3, 3, 2);            // granted, slot 5 released
        send_fields(MODE_REQUEST, 3'd1, 1, 2, 2);            // granted, slot released
        send_fields(MODE_SET_POOL, 3'd0, 250, 0, 1);
        send_fields(MODE_LOAD_ALC, 3'd5, 200, 1, 0);
        send_fields(MODE_LOAD_MAX, 3'd5, 201, 1, 0);
        send_fields(MODE_REQUEST, 3'd5, 1, 0, 0);            // pool saturates on release
        send_fields(MODE_CHECK, 3'd0, 0, 0, 0);
    endtask

    // mostly well-formed traffic: moderate pool, requests within need
    task automatic test_random_traffic();
        int sel;
        int p;
        int a[NTYPE];
        int lim;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            idle_pct = (i >= 100 && i < 160) ? 0 : 21;
            sel = $urandom_range(99);
            p = $urandom_range(NSLOT - 1);
            for (int t = 0; t < NTYPE; t++) a[t] = $urandom_range(CMAXV);
            if (sel < 3) begin
                send_fields($urandom_range(1) ? MODE_UNUSED_6 : MODE_UNUSED_7, 3'(p),
                            a[0], a[1], a[2]);
            end else if (sel < 8) begin
                send_fields(3'($urandom_range(2)), 3'(p), a[0], a[1], a[2]); // full-range noise
            end else if (sel < 20) begin
                for (int t = 0; t < NTYPE; t++) a[t] = $urandom_range(12);
                send_fields(MODE_LOAD_MAX, 3'(p), a[0], a[1], a[2]);
            end else if (sel < 30) begin
                for (int t = 0; t < NTYPE; t++) a[t] = $urandom_range(demand_tbl[p][t]);
                send_fields(MODE_LOAD_ALC, 3'(p), a[0], a[1], a[2]);
            end else if (sel < 38) begin
                for (int t = 0; t < NTYPE; t++) a[t] = $urandom_range(15);
                send_fields(MODE_SET_POOL, 3'(p), a[0], a[1], a[2]);
            end else if (sel < 45) begin
                send_fields(MODE_CHECK, 3'(p), a[0], a[1], a[2]);
            end else begin
                // request or trial with amounts mostly within need
                for (int t = 0; t < NTYPE; t++) begin
                    lim = demand_tbl[p][t] > alloc_tbl[p][t] ? demand_tbl[p][t] - alloc_tbl[p][t] : 0;
                    a[t] = ($urandom_range(9) == 0) ? $urandom_range(lim + 3) : $urandom_range(lim);
                end
                send_fields(sel < 80 ? MODE_REQUEST : MODE_TRIAL, 3'(p), a[0], a[1], a[2]);
            end
        end
    endtask

    initial begin
        int waited;
        errors = 0;
        idle_pct = 21;
        stall_cycles = 0;
        start = 1'b0;
        i_req = '0;
        i_rst_n = 1'b0;
        live_slots = '0;
        for (int p = 0; p < NSLOT; p++)
            for (int t = 0; t < NTYPE; t++) begin
                demand_tbl[p][t] = 0;
                alloc_tbl[p][t] = 0;
            end
        for (int t = 0; t < NTYPE; t++) pool_now[t] = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_loads_and_empty_state();
        test_bound_checks_and_scan();
        test_random_traffic();

        @(negedge i_clk);
        start <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < STALL_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        repeat (200) @(posedge i_clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

### sim.f
rtl/core/bsa_pkg.sv
rtl/core/bankers_safety_allocator.sv
rtl/core/bsa_checker.sv
tb/sv/tb_bankers_safety_allocator.sv
